@@ sv/fdrs_pkg.sv @@
// Shared constants for the flip-dot row scan sequencer.
// Phase codes, configuration register indexes and fixed field widths.
// No dependencies.
package fdrs_pkg;

  // Hard cap on drive phases produced for one row
  localparam int MaxPhases = 64;
  localparam int CntW      = $clog2(MaxPhases + 1);

  localparam int PhaseW  = 3;
  localparam int HoldW   = 16;
  localparam int RowIdxW = 4;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;
  localparam int GapPosW = 6;
  localparam int GapRepW = 3;

  // Drive phase codes
  localparam logic [PhaseW-1:0] PH_SELECT  = 3'd0;
  localparam logic [PhaseW-1:0] PH_DATA    = 3'd1;
  localparam logic [PhaseW-1:0] PH_STROBE  = 3'd2;
  localparam logic [PhaseW-1:0] PH_WHITE   = 3'd3;
  localparam logic [PhaseW-1:0] PH_BLACK   = 3'd4;
  localparam logic [PhaseW-1:0] PH_RELEASE = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_CLOCK_PULSE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_STROBE_PULSE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FLIP_PULSE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAP_POSITION = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GAP_REPEAT   = 3'd4;

  // Register reset values
  localparam logic [7:0]         CLOCK_PULSE_RST  = 8'd1;
  localparam logic [7:0]         STROBE_PULSE_RST = 8'd1;
  localparam logic [HoldW-1:0]   FLIP_PULSE_RST   = 16'd1000;
  localparam logic [GapPosW-1:0] GAP_POSITION_RST = 6'd20;
  localparam logic [GapRepW-1:0] GAP_REPEAT_RST   = 3'd4;

endpackage

@@ sv/flipdot_row_scan_sequencer_core.sv @@
// Top level of the flip-dot row scan sequencer.
// Depends on fdrs_pkg and on fdrs_cell, which forms the serial bit chain.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) transfers one display row: a row
//   index and DATA_BITS pixel bits. Output channel (out_valid_o / out_stall_i)
//   transfers one drive phase per beat: ROWS one-hot select bits, the data
//   bits (gap bit repeated up to gap_repeat extra times), then strobe, white flip,
//   black flip and release. Release carries last_o. No row yields more than
//   64 phases; phases beyond that are dropped.
//   Configuration port (cfg_valid_i / cfg_ready_o) is always ready; write it
//   only while the block is idle. Indexes beyond the register list are ignored.
// Timing:
//   The row transfer sets the sequencer busy; each phase then passes through
//   the output register. While out_stall_i is low, one phase per cycle follows;
//   a row is ROWS + DATA_BITS + extra + 4 phases (60 to 64 at default sizes).
//   The next row is accepted in the cycle the final phase of the current row is
//   registered, so rows follow with no bubble.
// Reset clears the sequencer and output valid and loads register defaults.
// A stall on the output freezes the chain and sequencer; nothing is lost.
module flipdot_row_scan_sequencer_core #(
  parameter int ROWS      = 16,
  parameter int DATA_BITS = 40
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // row input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [fdrs_pkg::RowIdxW-1:0]   row_index_i,
  input  logic [DATA_BITS-1:0]           row_pixels_i,
  // phase output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fdrs_pkg::PhaseW-1:0]    phase_o,
  output logic                           bit_value_o,
  output logic [fdrs_pkg::HoldW-1:0]     hold_us_o,
  output logic                           last_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fdrs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fdrs_pkg::CfgDataW-1:0]  cfg_data_i
);

  import fdrs_pkg::*;

  localparam int ChainLen = ROWS + DATA_BITS;
  localparam int SelW     = $clog2(ROWS);
  localparam int DatW     = $clog2(DATA_BITS);
  // Room left for gap repeats under the phase cap, clamped to the register range
  localparam int RoomRaw  = MaxPhases - ROWS - DATA_BITS - 4;
  localparam int RoomPos  = (RoomRaw < 0) ? 0 : RoomRaw;
  localparam int Room     = (RoomPos > 7) ? 7 : RoomPos;

  typedef enum logic [2:0] {
    SEG_SELECT,
    SEG_DATA,
    SEG_STROBE,
    SEG_WHITE,
    SEG_BLACK,
    SEG_RELEASE
  } seg_e;

  // Configuration registers
  logic [7:0]         clock_pulse_q;
  logic [7:0]         strobe_pulse_q;
  logic [HoldW-1:0]   flip_pulse_q;
  logic [GapPosW-1:0] gap_position_q;
  logic [GapRepW-1:0] gap_repeat_q;

  // Sequencer state
  seg_e               seg_q, seg_d;
  logic               busy_q;
  logic [SelW-1:0]    sel_idx_q, sel_idx_d;
  logic [DatW-1:0]    dat_idx_q, dat_idx_d;
  logic [GapRepW-1:0] rep_q, rep_d;
  logic [CntW-1:0]    count_q;

  // Output register
  logic               out_valid_q;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic               bit_q, bit_d;
  logic [HoldW-1:0]   hold_q, hold_d;
  logic               last_q, last_d;

  logic               advance;
  logic               emit;
  logic               finish;
  logic               shift_req;
  logic               shift_en;
  logic               in_xfer;
  logic               gap_hit;
  logic [GapRepW-1:0] extra;

  // Bit chain: select bits first, then pixels; cell 0 is the head
  logic [ChainLen-1:0] load_bits;
  logic [ChainLen:0]   chain;

  assign chain[ChainLen] = 1'b0;

  for (genvar k = 0; k < ChainLen; k++) begin : g_chain
    if (k < ROWS) begin : g_sel
      assign load_bits[k] = (int'(row_index_i) == k);
    end else begin : g_pix
      assign load_bits[k] = row_pixels_i[k-ROWS];
    end

    fdrs_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (in_xfer),
      .shift_i    (shift_en),
      .load_bit_i (load_bits[k]),
      .next_bit_i (chain[k+1]),
      .bit_o      (chain[k])
    );
  end

  assign extra   = (gap_repeat_q > GapRepW'(Room)) ? GapRepW'(Room) : gap_repeat_q;
  assign gap_hit = (GapPosW'(dat_idx_q) == gap_position_q) &&
                   (dat_idx_q != DatW'(DATA_BITS - 1));

  always_comb begin
    advance   = !out_valid_q || !out_stall_i;
    emit      = busy_q && advance;
    seg_d     = seg_q;
    sel_idx_d = sel_idx_q;
    dat_idx_d = dat_idx_q;
    rep_d     = rep_q;
    shift_req = 1'b0;
    finish    = 1'b0;
    phase_d   = PH_SELECT;
    bit_d     = chain[0];
    hold_d    = HoldW'(clock_pulse_q);
    last_d    = 1'b0;
    case (seg_q)
      SEG_SELECT: begin
        shift_req = 1'b1;
        if (sel_idx_q == SelW'(ROWS - 1)) begin
          seg_d     = SEG_DATA;
          sel_idx_d = '0;
        end else begin
          sel_idx_d = sel_idx_q + 1'b1;
        end
      end
      SEG_DATA: begin
        phase_d = PH_DATA;
        // Hold the gap bit at the head until its extra copies are out
        if (gap_hit && rep_q != extra) begin
          rep_d = rep_q + 1'b1;
        end else begin
          rep_d     = '0;
          shift_req = 1'b1;
          if (dat_idx_q == DatW'(DATA_BITS - 1)) begin
            seg_d     = SEG_STROBE;
            dat_idx_d = '0;
          end else begin
            dat_idx_d = dat_idx_q + 1'b1;
          end
        end
      end
      SEG_STROBE: begin
        phase_d = PH_STROBE;
        bit_d   = 1'b0;
        hold_d  = HoldW'(strobe_pulse_q);
        seg_d   = SEG_WHITE;
      end
      SEG_WHITE: begin
        phase_d = PH_WHITE;
        bit_d   = 1'b0;
        hold_d  = flip_pulse_q;
        seg_d   = SEG_BLACK;
      end
      SEG_BLACK: begin
        phase_d = PH_BLACK;
        bit_d   = 1'b0;
        hold_d  = flip_pulse_q;
        seg_d   = SEG_RELEASE;
      end
      SEG_RELEASE: begin
        phase_d = PH_RELEASE;
        bit_d   = 1'b0;
        hold_d  = '0;
        last_d  = 1'b1;
        finish  = 1'b1;
      end
      default: begin
        seg_d  = SEG_SELECT;
        finish = 1'b1;
      end
    endcase
    // Drop the rest of the row once the phase cap is reached
    if (count_q == CntW'(MaxPhases - 1)) begin
      finish = 1'b1;
    end
  end

  assign shift_en    = emit && shift_req;
  assign in_stall_o  = busy_q && !(emit && finish);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_pulse_q  <= CLOCK_PULSE_RST;
      strobe_pulse_q <= STROBE_PULSE_RST;
      flip_pulse_q   <= FLIP_PULSE_RST;
      gap_position_q <= GAP_POSITION_RST;
      gap_repeat_q   <= GAP_REPEAT_RST;
      seg_q          <= SEG_SELECT;
      busy_q         <= 1'b0;
      sel_idx_q      <= '0;
      dat_idx_q      <= '0;
      rep_q          <= '0;
      count_q        <= '0;
      out_valid_q    <= 1'b0;
      phase_q        <= PH_SELECT;
      bit_q          <= 1'b0;
      hold_q         <= '0;
      last_q         <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_CLOCK_PULSE:  clock_pulse_q  <= cfg_data_i[7:0];
          REG_STROBE_PULSE: strobe_pulse_q <= cfg_data_i[7:0];
          REG_FLIP_PULSE:   flip_pulse_q   <= cfg_data_i;
          REG_GAP_POSITION: gap_position_q <= cfg_data_i[GapPosW-1:0];
          REG_GAP_REPEAT:   gap_repeat_q   <= cfg_data_i[GapRepW-1:0];
          default: begin
          end
        endcase
      end
      if (advance) begin
        out_valid_q <= emit;
      end
      if (emit) begin
        phase_q   <= phase_d;
        bit_q     <= bit_d;
        hold_q    <= hold_d;
        last_q    <= last_d;
        seg_q     <= seg_d;
        sel_idx_q <= sel_idx_d;
        dat_idx_q <= dat_idx_d;
        rep_q     <= rep_d;
        count_q   <= count_q + 1'b1;
        if (finish) begin
          busy_q <= 1'b0;
        end
      end
      // A new row restarts the sequencer; takes priority over the finish above
      if (in_xfer) begin
        busy_q    <= 1'b1;
        seg_q     <= SEG_SELECT;
        sel_idx_q <= '0;
        dat_idx_q <= '0;
        rep_q     <= '0;
        count_q   <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign phase_o     = phase_q;
  assign bit_value_o = bit_q;
  assign hold_us_o   = hold_q;
  assign last_o      = last_q;

  // Only the release phase is flagged as last
  a_last_is_release: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (phase_o == PH_RELEASE && hold_us_o == '0)
  ) else $error("last flagged on a phase other than release");

  // A row transfer always starts the sequencer
  a_xfer_starts: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (busy_q && count_q == '0 && seg_q == SEG_SELECT)
  ) else $error("row transfer did not restart the sequencer");

  // Never more phases per row than the cap
  a_phase_cap: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (count_q < CntW'(MaxPhases))
  ) else $error("phase count exceeded the cap");

  // A stalled output register keeps its phase
  a_stall_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(phase_o) && $stable(bit_value_o))
  ) else $error("output changed under stall");

endmodule

@@ sv/fdrs_cell.sv @@
// One storage cell of the serial bit chain of the row scan sequencer.
// Loads a bit in parallel or takes its neighbor's bit on a shift.
// No dependencies.
module fdrs_cell (
  input  logic clk_i,
  input  logic load_i,
  input  logic shift_i,
  input  logic load_bit_i,
  input  logic next_bit_i,
  output logic bit_o
);

  logic bit_q;
  logic bit_d;

  always_comb begin
    bit_d = bit_q;
    if (load_i) begin
      bit_d = load_bit_i;
    end else if (shift_i) begin
      bit_d = next_bit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign bit_o = bit_q;

endmodule

@@ tb/flipdot_row_scan_sequencer_core_tb.sv @@
// Testbench for flipdot_row_scan_sequencer_core: drives display rows, predicts every drive
// phase from a local model of the registers and checks each output transfer in order.
// Depends on fdrs_pkg and the core RTL only.
module flipdot_row_scan_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdrs_pkg::*;

  localparam int ROWS      = 16;
  localparam int DATA_BITS = 40;
  // Room left for gap repeats once the fixed phases are counted
  localparam int GapRoom = (MaxPhases - ROWS - DATA_BITS - 4 < 0) ? 0 :
                           MaxPhases - ROWS - DATA_BITS - 4;
  // Indexes past the register list; the core must ignore writes to them
  localparam logic [CfgIdxW-1:0] REG_UNUSED_LO  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_MID = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_HI  = 3'd7;
  localparam int QuietLimit    = 2000;  // cycles with no transfer before giving up
  localparam int LongHoldCycles = 200;  // receiver hold-off used to back up the core

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              bit_value;
    logic [HoldW-1:0]  hold_us;
    logic              last;
  } drive_phase_t;

  typedef struct {
    logic [RowIdxW-1:0]   row_idx;
    logic [DATA_BITS-1:0] pixels;
  } row_item_t;

  // DUT ports; every input starts at a known value
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [RowIdxW-1:0]   row_index_i  = '0;
  logic [DATA_BITS-1:0] row_pixels_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [PhaseW-1:0]    phase_o;
  logic                 bit_value_o;
  logic [HoldW-1:0]     hold_us_o;
  logic                 last_o;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i  = '0;
  logic [CfgDataW-1:0]  cfg_data_i   = '0;

  // Local copy of the register file, used by the phase predictor
  logic [7:0]         cfg_clock_us  = CLOCK_PULSE_RST;
  logic [7:0]         cfg_strobe_us = STROBE_PULSE_RST;
  logic [HoldW-1:0]   cfg_flip_us   = FLIP_PULSE_RST;
  logic [GapPosW-1:0] cfg_gap_pos   = GAP_POSITION_RST;
  logic [GapRepW-1:0] cfg_gap_rep   = GAP_REPEAT_RST;

  row_item_t    row_backlog[$];     // rows waiting to be offered
  drive_phase_t pending_phases[$];  // predicted phases not yet seen on the output

  // Idle controls, set by the stimulus between groups of rows
  bit src_idle_on = 1'b0;
  bit snk_idle_on = 1'b0;
  int hold_requests = 0;

  int err_count      = 0;
  int rows_sent      = 0;
  int phases_checked = 0;
  int reg_writes     = 0;
  int settings_run   = 1;

  flipdot_row_scan_sequencer_core #(
    .ROWS      (ROWS),
    .DATA_BITS (DATA_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .row_index_i  (row_index_i),
    .row_pixels_i (row_pixels_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .phase_o      (phase_o),
    .bit_value_o  (bit_value_o),
    .hold_us_o    (hold_us_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 20) $display("MISMATCH %0d: %s", err_count, msg);
  endtask

  // Append one predicted phase; drop anything past the per-row cap
  function automatic void add_phase(inout int n, input logic [PhaseW-1:0] ph,
                                    input logic level, input logic [HoldW-1:0] hold,
                                    input logic fin);
    drive_phase_t p;
    if (n >= MaxPhases) return;
    p.phase     = ph;
    p.bit_value = level;
    p.hold_us   = hold;
    p.last      = fin;
    pending_phases.push_back(p);
    n++;
  endfunction

  // Predict the full drive sequence for one row under the current registers
  function automatic void scan_row_phases(input logic [RowIdxW-1:0] row_idx,
                                          input logic [DATA_BITS-1:0] pixels);
    int n;
    int extra;
    n = 0;
    // Saturate the gap repeats so the row fits the phase cap
    extra = (int'(cfg_gap_rep) > GapRoom) ? GapRoom : int'(cfg_gap_rep);
    // One-hot select bits; only the addressed row carries a one
    for (int r = 0; r < ROWS; r++)
      add_phase(n, PH_SELECT, r == int'(row_idx), {8'd0, cfg_clock_us}, 1'b0);
    // Data bits, LSB first; the gap bit repeats only if another bit follows it
    for (int i = 0; i < DATA_BITS; i++) begin
      add_phase(n, PH_DATA, pixels[i], {8'd0, cfg_clock_us}, 1'b0);
      if (i == int'(cfg_gap_pos) && i + 1 < DATA_BITS) begin
        for (int k = 0; k < extra; k++)
          add_phase(n, PH_DATA, pixels[i], {8'd0, cfg_clock_us}, 1'b0);
      end
    end
    add_phase(n, PH_STROBE, 1'b0, {8'd0, cfg_strobe_us}, 1'b0);
    add_phase(n, PH_WHITE, 1'b0, cfg_flip_us, 1'b0);
    add_phase(n, PH_BLACK, 1'b0, cfg_flip_us, 1'b0);
    add_phase(n, PH_RELEASE, 1'b0, '0, 1'b1);
  endfunction

  // Row driver: predict on every accepted transfer, then present the next row
  // or idle for a short burst. Hold the payload steady while stalled.
  always @(posedge clk_i) begin : row_driver
    row_item_t next_row;
    int src_gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        scan_row_phases(row_index_i, row_pixels_i);
        rows_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid_i <= 1'b0;
        end else if (row_backlog.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (src_idle_on && $urandom_range(0, 3) == 0) begin
          // Start an idle burst
          src_gap = $urandom_range(0, 2);
          in_valid_i <= 1'b0;
        end else begin
          next_row = row_backlog.pop_front();
          in_valid_i   <= 1'b1;
          row_index_i  <= next_row.row_idx;
          row_pixels_i <= next_row.pixels;
        end
      end
    end
  end

  // Phase monitor: check each output transfer against the oldest prediction,
  // then choose the stall for the next cycle (long hold-off, burst or none).
  always @(posedge clk_i) begin : phase_monitor
    drive_phase_t want;
    int snk_gap;
    int hold_left;
    int hold_served;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      snk_gap = 0;
      hold_left = 0;
      hold_served = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_phases.size() == 0) begin
          report_mismatch($sformatf("unexpected phase %0d (bit %0d hold %0d last %0d)",
                                    phase_o, bit_value_o, hold_us_o, last_o));
        end else begin
          want = pending_phases.pop_front();
          if (phase_o !== want.phase)
            report_mismatch($sformatf("transfer %0d: phase %0d, want %0d",
                                      phases_checked, phase_o, want.phase));
          if (bit_value_o !== want.bit_value)
            report_mismatch($sformatf("transfer %0d: bit_value %0d, want %0d",
                                      phases_checked, bit_value_o, want.bit_value));
          if (hold_us_o !== want.hold_us)
            report_mismatch($sformatf("transfer %0d: hold_us %0d, want %0d",
                                      phases_checked, hold_us_o, want.hold_us));
          if (last_o !== want.last)
            report_mismatch($sformatf("transfer %0d: last %0d, want %0d",
                                      phases_checked, last_o, want.last));
        end
        phases_checked++;
      end
      // Pick up a long hold-off request from the stimulus
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_stall_i <= 1'b1;
      end else if (snk_idle_on && $urandom_range(0, 4) == 0) begin
        snk_gap = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if no transfer happens on any channel for too long
  always @(posedge clk_i) begin : watchdog
    int quiet_cycles;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d quiet cycles, %0d phases outstanding",
               quiet_cycles, pending_phases.size());
      $display("flipdot_row_scan_sequencer_core_tb failed");
      $finish;
    end
  end

  // Write one register and mirror it locally; indexes past the list are dropped
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      REG_CLOCK_PULSE:  cfg_clock_us  = data[7:0];
      REG_STROBE_PULSE: cfg_strobe_us = data[7:0];
      REG_FLIP_PULSE:   cfg_flip_us   = data[HoldW-1:0];
      REG_GAP_POSITION: cfg_gap_pos   = data[GapPosW-1:0];
      REG_GAP_REPEAT:   cfg_gap_rep   = data[GapRepW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic queue_row(input logic [RowIdxW-1:0] idx, input logic [DATA_BITS-1:0] pix);
    row_item_t r;
    r.row_idx = idx;
    r.pixels  = pix;
    row_backlog.push_back(r);
  endtask

  // Pause the sender until every row is taken and every predicted phase has come
  task automatic wait_drained();
    do @(negedge clk_i);
    while (row_backlog.size() != 0 || in_valid_i || pending_phases.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  // Zero, full scale or random 16-bit write data (upper bits test masking)
  function automatic logic [CfgDataW-1:0] pick_value(input logic [CfgDataW-1:0] top);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return top;
      default: return CfgDataW'($urandom());
    endcase
  endfunction

  function automatic logic [DATA_BITS-1:0] random_pixels();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {{(DATA_BITS-1){1'b0}}, 1'b1} << cfg_gap_pos;  // lone gap bit
      default: return raw[DATA_BITS-1:0];
    endcase
  endfunction

  task automatic random_settings();
    write_reg(REG_CLOCK_PULSE, pick_value(16'h00FF));
    write_reg(REG_STROBE_PULSE, pick_value(16'h00FF));
    write_reg(REG_FLIP_PULSE, pick_value(16'hFFFF));
    // Mostly legal gap positions, sometimes past the last data bit
    write_reg(REG_GAP_POSITION, ($urandom_range(0, 3) == 0) ?
              CfgDataW'($urandom_range(0, 63)) : CfgDataW'($urandom_range(0, 38)));
    write_reg(REG_GAP_REPEAT, CfgDataW'($urandom_range(0, 7)));
    if ($urandom_range(0, 1) == 0)
      write_reg(CfgIdxW'($urandom_range(int'(REG_UNUSED_LO), int'(REG_UNUSED_HI))),
                CfgDataW'($urandom()));
    settings_run++;
  endtask

  initial begin
    // Hold reset, then release it away from the rising edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows at reset settings: select extremes, data patterns, gap bit
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    queue_row(4'd0, '0);
    queue_row(4'd15, '1);
    queue_row(4'd5, 40'hAA_AAAA_AAAA);
    queue_row(4'd10, 40'h55_5555_5555);
    queue_row(4'd3, 40'd1 << 20);
    queue_row(4'd7, 40'd1 << 21);
    queue_row(4'd9, (40'd1 << 39) | 40'd1);
    wait_drained();

    // Full-scale clock and flip pulses, zero strobe pulse, gap at bit 0 with no repeats; unused indexes ignored
    write_reg(REG_CLOCK_PULSE, 16'hFFFF);
    write_reg(REG_STROBE_PULSE, 16'h0000);
    write_reg(REG_FLIP_PULSE, 16'hFFFF);
    write_reg(REG_GAP_POSITION, 16'h0000);
    write_reg(REG_GAP_REPEAT, 16'h0000);
    write_reg(REG_UNUSED_LO, 16'hFFFF);
    write_reg(REG_UNUSED_HI, 16'h0000);
    write_reg(REG_UNUSED_MID, 16'hFFFF);
    settings_run++;
    queue_row(4'd1, 40'd1);
    queue_row(4'd14, '1);
    wait_drained();

    // Zero clock and flip pulses, last legal gap position, repeat saturates
    write_reg(REG_CLOCK_PULSE, 16'h0000);
    write_reg(REG_STROBE_PULSE, 16'h00FF);
    write_reg(REG_FLIP_PULSE, 16'h0000);
    write_reg(REG_GAP_POSITION, 16'd38);
    write_reg(REG_GAP_REPEAT, 16'd7);
    settings_run++;
    queue_row(4'd2, 40'd1 << 38);
    queue_row(4'd13, random_pixels());
    wait_drained();

    // Gap on the last data bit: nothing follows, so no repeats
    write_reg(REG_GAP_POSITION, 16'd39);
    write_reg(REG_GAP_REPEAT, 16'd5);
    settings_run++;
    queue_row(4'd4, '1);
    queue_row(4'd6, 40'd1 << 39);
    wait_drained();

    // Gap position far past the data width
    write_reg(REG_GAP_POSITION, 16'hFFFF);
    write_reg(REG_GAP_REPEAT, 16'd4);
    settings_run++;
    queue_row(4'd8, random_pixels());
    queue_row(4'd11, '1);
    wait_drained();

    // Random groups of rows, each under fresh settings. Group 1 runs with no
    // idling, group 2 backs the core up behind a long receiver hold-off, and
    // the last two groups run without idling to finish at full rate.
    for (int grp = 0; grp < 6; grp++) begin
      random_settings();
      src_idle_on = (grp < 4) && (grp != 1);
      snk_idle_on = (grp < 4) && (grp != 1);
      if (grp == 2) hold_requests++;
      for (int k = 0; k < 16; k++)
        queue_row(RowIdxW'($urandom_range(0, ROWS - 1)), random_pixels());
      wait_drained();
    end

    // Let any stray output surface before the final check
    repeat (8) @(negedge clk_i);
    if (pending_phases.size() != 0)
      report_mismatch($sformatf("%0d predicted phases never arrived", pending_phases.size()));

    $display("Covered %0d rows and %0d drive phases under %0d register settings (%0d writes),",
             rows_sent, phases_checked, settings_run, reg_writes);
    $display("including pulse extremes, gap saturation, end-of-row gaps and ignored indexes.");
    if (err_count == 0) begin
      $display("flipdot_row_scan_sequencer_core_tb passed");
    end else begin
      $display("flipdot_row_scan_sequencer_core_tb failed");
    end
    $finish;
  end

endmodule

@@ flipdot_row_scan_sequencer_core.f @@
sv/fdrs_pkg.sv
sv/fdrs_cell.sv
sv/flipdot_row_scan_sequencer_core.sv
tb/flipdot_row_scan_sequencer_core_tb.sv
